[hdl/dda_line_rasterizer_assert.svh]
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define DDA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dda_line_rasterizer: assertion failed");

// Next-cycle implication, checked on the rising edge of clk_i outside reset.
`define DDA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dda_line_rasterizer: assertion failed");

`endif

[hdl/dda_pkg.sv]
// Types and constants of the DDA line rasterizer.
package dda_pkg;

  // Width of the screen-centre registers
  localparam int unsigned CEN_W = 10;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOAD,
    S_DIV,
    S_STORE,
    S_SUM,
    S_EMIT
  } dda_state_e;

endpackage

[hdl/dda_line_rasterizer.sv]
// DDA line rasterizer: sequencer, shared restoring divider and pixel stage.
//
// Usage: requests enter on in_valid_i/in_stall_o with op_i and four signed
// endpoints. A load request (op_i = 0) computes the step count and the two
// per-step increments, then delivers the start pixel. A step request
// (op_i = 1) advances the position by one increment and delivers one pixel;
// last_o marks the final pixel of the line. A step with no line in progress
// produces nothing. Pixels leave on out_valid_o/out_stall_i from an output
// register; the block takes its next request while a pixel still waits.
// A step request runs the sum and emit states, then the block is idle again.
// A load request runs the shared bit-serial divider once per axis before the
// sum and emit states; a zero-length line skips the divider. in_stall_o is
// high whenever the sequencer is not idle. A stalled receiver holds the
// sequencer in its emit state until the output register frees up. Reset
// (rst_ni low) empties the output register, clears the line state and both
// centre registers. cfg_we_i writes centre x (index 0) or centre y (index 1);
// the user is to write them only while the block is idle, as the block
// itself does not enforce it.
`include "dda_line_rasterizer_assert.svh"

module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [dda_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dda_pkg::CEN_W-1:0]         cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  // pixel channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS:0]        pixel_x_o,
  output logic signed [COORD_BITS:0]        pixel_y_o,
  output logic                              axis_colour_o,
  output logic                              last_o
);
  import dda_pkg::*;

  // Derived widths
  localparam int unsigned D_W    = COORD_BITS + 1;           // endpoint difference
  localparam int unsigned STEP_W = COORD_BITS + 1;           // step count
  localparam int unsigned QW     = FRAC_BITS + 1;            // quotient magnitude
  localparam int unsigned NW     = COORD_BITS + FRAC_BITS + 1; // dividend
  localparam int unsigned REM_W  = COORD_BITS + 2;           // partial remainder
  localparam int unsigned INC_W  = FRAC_BITS + 2;            // signed increment
  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS + 1; // signed position
  localparam int unsigned SUM_BASE = (POS_W > CEN_W + FRAC_BITS + 1) ?
                                     POS_W : (CEN_W + FRAC_BITS + 1);
  localparam int unsigned SUM_W  = SUM_BASE + 1;             // centred position
  localparam int unsigned CNT_W  = $clog2(QW);

  dda_state_e state_q, state_d;

  logic [CEN_W-1:0]        cen_x_q, cen_y_q;
  logic signed [POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [INC_W-1:0] inc_x_q, inc_y_q;
  logic signed [D_W-1:0]   dx_q, dy_q;
  logic [D_W-1:0]          ax_q, ay_q;
  logic [STEP_W-1:0]       steps_q, steps_left_q;
  logic                    busy_q, last_q, div_y_q;
  logic [REM_W-1:0]        rem_q;
  logic [QW-1:0]           sh_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic                    axis_q;

  logic                    out_valid_q;
  logic signed [COORD_BITS:0] pixel_x_q, pixel_y_q;
  logic                    axis_colour_q, last_out_q;

  // Handshake and control strobes
  logic in_acc, out_free, emit_go;

  // Combinational datapath values
  logic signed [D_W-1:0]   xs_ext, ys_ext, xe_ext, ye_ext;
  logic [D_W-1:0]          ax_c, ay_c;
  logic [STEP_W-1:0]       steps_c;
  logic [D_W-1:0]          d_mag;
  logic [NW-1:0]           num_c;
  logic [REM_W-1:0]        trial, steps_ext;
  logic                    ge;
  logic signed [INC_W-1:0] q_pos, q_signed;
  logic                    q_neg;
  logic [SUM_W-1:0]        cx_fix, cy_fix, pos_x_ext, pos_y_ext;
  logic [SUM_W-1:0]        bias_x, bias_y, tx, ty;
  logic                    axis_c;

  // ---------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_LOAD) begin
            state_d = S_PREP;
          end else if (busy_q) begin
            state_d = S_SUM;
          end
        end
      end
      S_PREP: begin
        state_d = (steps_c == '0) ? S_SUM : S_LOAD;
      end
      S_LOAD:  state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_STORE;
        end
      end
      S_STORE: state_d = div_y_q ? S_SUM : S_LOAD;
      S_SUM:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    emit_go    = 1'b0;
    case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_EMIT:  emit_go    = out_free;
      default: begin
        in_stall_o = 1'b1;
        emit_go    = 1'b0;
      end
    endcase
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------
  // Setup: differences, magnitudes, step count
  // ---------------------------------------------------------------
  assign xs_ext = D_W'(x_start_i);
  assign ys_ext = D_W'(y_start_i);
  assign xe_ext = D_W'(x_end_i);
  assign ye_ext = D_W'(y_end_i);

  assign ax_c    = dx_q[D_W-1] ? D_W'(-dx_q) : D_W'(dx_q);
  assign ay_c    = dy_q[D_W-1] ? D_W'(-dy_q) : D_W'(dy_q);
  assign steps_c = (ax_c >= ay_c) ? ax_c : ay_c;

  // ---------------------------------------------------------------
  // Shared divider: (|d| << F + steps/2) / steps, one bit a cycle
  // ---------------------------------------------------------------
  assign d_mag     = div_y_q ? ay_q : ax_q;
  assign num_c     = {d_mag, {FRAC_BITS{1'b0}}} + NW'(steps_q >> 1);
  assign steps_ext = {1'b0, steps_q};
  assign trial     = {rem_q[REM_W-2:0], sh_q[QW-1]};
  assign ge        = trial >= steps_ext;

  // Sign the quotient with the difference being divided
  assign q_neg    = div_y_q ? dy_q[D_W-1] : dx_q[D_W-1];
  assign q_pos    = $signed({1'b0, sh_q});
  assign q_signed = q_neg ? -q_pos : q_pos;

  // ---------------------------------------------------------------
  // Pixel stage: centre offset with y mirrored (none when both centres are zero), then truncation toward zero
  // ---------------------------------------------------------------
  assign axis_c    = (cen_x_q == '0) && (cen_y_q == '0);
  assign cx_fix    = {{(SUM_W-CEN_W-FRAC_BITS){1'b0}}, cen_x_q, {FRAC_BITS{1'b0}}};
  assign cy_fix    = {{(SUM_W-CEN_W-FRAC_BITS){1'b0}}, cen_y_q, {FRAC_BITS{1'b0}}};
  assign pos_x_ext = {{(SUM_W-POS_W){pos_x_q[POS_W-1]}}, pos_x_q};
  assign pos_y_ext = {{(SUM_W-POS_W){pos_y_q[POS_W-1]}}, pos_y_q};

  assign bias_x = {{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_x_q[SUM_W-1]}}};
  assign bias_y = {{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_y_q[SUM_W-1]}}};
  assign tx     = $unsigned($signed(sum_x_q + bias_x) >>> FRAC_BITS);
  assign ty     = $unsigned($signed(sum_y_q + bias_y) >>> FRAC_BITS);

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      busy_q       <= 1'b0;
      steps_left_q <= '0;
      div_y_q      <= 1'b0;
      cnt_q        <= '0;
      cen_x_q      <= '0;
      cen_y_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CENTER_X: cen_x_q <= cfg_data_i;
          CFG_CENTER_Y: cen_y_q <= cfg_data_i;
          default: ;
        endcase
      end

      // line progress
      if (state_q == S_PREP) begin
        busy_q       <= (steps_c != '0);
        steps_left_q <= steps_c;
        div_y_q      <= 1'b0;
      end else if (in_acc && (op_i == OP_STEP) && busy_q) begin
        steps_left_q <= steps_left_q - STEP_W'(1);
        busy_q       <= (steps_left_q != STEP_W'(1));
      end

      // divider iteration count and axis select
      if (state_q == S_LOAD) begin
        cnt_q <= CNT_W'(QW - 1);
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (state_q == S_STORE) begin
        div_y_q <= 1'b1;
      end

      // output register
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && (op_i == OP_LOAD)) begin
          pos_x_q <= {{(POS_W-COORD_BITS-FRAC_BITS){x_start_i[COORD_BITS-1]}},
                      x_start_i, {FRAC_BITS{1'b0}}};
          pos_y_q <= {{(POS_W-COORD_BITS-FRAC_BITS){y_start_i[COORD_BITS-1]}},
                      y_start_i, {FRAC_BITS{1'b0}}};
          dx_q    <= xe_ext - xs_ext;
          dy_q    <= ye_ext - ys_ext;
        end else if (in_acc && busy_q) begin
          pos_x_q <= pos_x_q + POS_W'(inc_x_q);
          pos_y_q <= pos_y_q + POS_W'(inc_y_q);
          last_q  <= (steps_left_q == STEP_W'(1));
        end
      end
      S_PREP: begin
        ax_q    <= ax_c;
        ay_q    <= ay_c;
        steps_q <= steps_c;
        inc_x_q <= '0;
        inc_y_q <= '0;
        last_q  <= (steps_c == '0);
      end
      S_LOAD: begin
        rem_q <= {2'b00, num_c[NW-1:QW]};
        sh_q  <= num_c[QW-1:0];
      end
      S_DIV: begin
        rem_q <= ge ? (trial - steps_ext) : trial;
        sh_q  <= {sh_q[QW-2:0], ge};
      end
      S_STORE: begin
        if (div_y_q) begin
          inc_y_q <= q_signed;
        end else begin
          inc_x_q <= q_signed;
        end
      end
      S_SUM: begin
        axis_q  <= axis_c;
        sum_x_q <= axis_c ? $signed(pos_x_ext) : $signed(pos_x_ext + cx_fix);
        sum_y_q <= axis_c ? $signed(pos_y_ext) : $signed(cy_fix - pos_y_ext);
      end
      default: ;
    endcase

    // pixel out
    if (emit_go) begin
      pixel_x_q     <= $signed(tx[COORD_BITS:0]);
      pixel_y_q     <= $signed(ty[COORD_BITS:0]);
      axis_colour_q <= axis_q;
      last_out_q    <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign axis_colour_o = axis_colour_q;
  assign last_o        = last_out_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // a stalled full output register holds the sequencer in emit
  `DDA_ASSERT_NXT(a_emit_holds, (state_q == S_EMIT) && out_valid_q && out_stall_i, (state_q == S_EMIT) && out_valid_q)
  // a step with no line in progress leaves the block idle
  `DDA_ASSERT_NXT(a_idle_step, in_acc && (op_i == OP_STEP) && !busy_q, state_q == S_IDLE)
  // increment magnitude never exceeds one pixel
  `DDA_ASSERT_IMP(a_quot_range, state_q == S_STORE, sh_q <= (QW'(1) << FRAC_BITS))
  // a line in progress always has pixels left
  `DDA_ASSERT_IMP(a_busy_steps, (state_q == S_IDLE) && busy_q, steps_left_q != '0)

endmodule
